### rtl/wind_vane_direction_decode_defines.svh
// Assertion macros shared by the wind vane decoder RTL.
`ifndef WIND_VANE_DIRECTION_DECODE_DEFINES_SVH
`define WIND_VANE_DIRECTION_DECODE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WVD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wind vane decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wind vane decoder: next-cycle check failed");

`endif

### rtl/wvd_pkg.sv
// Types and constants of the wind vane direction decoder.
`default_nettype none

package wvd_pkg;

  // Field widths
  localparam int SMP_W     = 12;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = 18;
  localparam int HEAD_W    = 9;
  localparam int IDX_FLD_W = 4;
  localparam int OFFS_W    = 10;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Arithmetic constants
  localparam int MAX_SAMPLES = 64;
  localparam int DEG_MAX     = 359;
  localparam int DEG_FULL    = 360;
  localparam int PROD_W      = SMP_W + HEAD_W;
  localparam int LIN_SHIFT   = SMP_W;
  localparam int TOT_W       = 11;
  localparam int WRAP_BIAS   = 2 * DEG_FULL;

  // Input commands
  localparam logic CMD_SAMPLE    = 1'b0;
  localparam logic CMD_CAL_WRITE = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_CAL_MODE     = 2'd1;
  localparam logic [1:0] REG_CAL_USED     = 2'd2;
  localparam logic [1:0] REG_NORTH_OFFS   = 2'd3;

  typedef struct packed {
    logic                 command;
    logic [SMP_W-1:0]     adc_sample;
    logic [IDX_FLD_W-1:0] entry_index;
    logic [SMP_W-1:0]     entry_adc;
    logic [HEAD_W-1:0]    entry_heading;
  } wvd_in_t;

  typedef struct packed {
    logic [HEAD_W-1:0]    heading_deg;
    logic [SMP_W-1:0]     averaged_adc;
    logic [IDX_FLD_W-1:0] matched_entry;
  } wvd_out_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_WALK = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_LIN  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_WRAP = 7'b1000000
  } wvd_state_t;

endpackage

`default_nettype wire

### rtl/wvd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module wvd_div #(
  parameter int N_W = 18,
  parameter int D_W = 7
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int C_W = $clog2(N_W + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [C_W-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0] rem_r, rem_nxt;
  logic [N_W-1:0] quo_r, quo_nxt;
  logic [D_W-1:0] dvs_r, dvs_nxt;

  logic [D_W:0]   shifted;
  logic [D_W:0]   trial;
  logic           fits;

  // Trial subtract of the partial remainder
  assign shifted = {rem_r, quo_r[N_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  // Iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = C_W'(N_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[D_W-1:0] : shifted[D_W-1:0];
      quo_nxt = {quo_r[N_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == C_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### rtl/wind_vane_direction_decode.sv
// Wind vane direction decoder: sample averaging, calibration lookup, north offset.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   in_      | to block  | in_valid/in_stall  | wvd_in_t (sample or cal write)
//   out_     | from block| out_valid/out_stall| wvd_out_t (heading result)
//   cfg      | to block  | APB psel/penable   | four 32-bit registers
//
// A calibration write or a non-final sample of a burst does not stall the input.
// A burst-ending sample passes through the transfer, the bit-serial divider,
// then multiply and map in linear mode or one table read per used entry and
// a drain of the walk in calibrated mode, then the offset and wrap steps.
// rst_n is synchronous; the calibration memory has no reset.
// A result waits in the output register; a new result holds the sequencer in
// the wrap step, with the input stalled, until that register is free.
`default_nettype none
`include "wind_vane_direction_decode_defines.svh"

module wind_vane_direction_decode
  import wvd_pkg::*;
#(
  parameter int CAL_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire wvd_in_t            in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output wvd_out_t                out_data,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int IDX_W = (CAL_ENTRIES > 1) ? $clog2(CAL_ENTRIES) : 1;
  localparam int UW    = $clog2(CAL_ENTRIES + 1);
  localparam int ENT_W = SMP_W + HEAD_W;

  // Configuration registers
  logic [CNT_W-1:0]         sample_count_r;
  logic                     cal_mode_r;
  logic [4:0]               cal_used_r;
  logic signed [OFFS_W-1:0] north_offs_r;
  logic                     cfg_wr;
  logic [1:0]               cfg_idx;

  // Sequencer and datapath
  wvd_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic [SMP_W-1:0]  avg_r, avg_nxt;
  logic [UW-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [ENT_W-1:0]  rd_q_r;
  logic [SMP_W-1:0]  best_r, best_nxt;
  logic [IDX_W-1:0]  match_r, match_nxt;
  logic [HEAD_W-1:0] raw_r, raw_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic              out_valid_r, out_valid_nxt;
  wvd_out_t          out_data_r, out_data_nxt;

  logic [ENT_W-1:0]  cal_mem [CAL_ENTRIES];

  logic              in_acc;
  logic              is_sample;
  logic              burst_done;
  logic [CNT_W-1:0]  limit_c;
  logic [CNT_W-1:0]  taken_inc;
  logic [SUM_W-1:0]  sum_inc;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic [UW-1:0]     used_c;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [SMP_W-1:0]  rd_adc;
  logic [HEAD_W-1:0] rd_head;
  logic [SMP_W-1:0]  diff;
  logic              take;
  logic [PROD_W:0]   lin_sum;
  logic [TOT_W-1:0]  wrapped;
  logic              out_free;

  // APB register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CNT_W'(16);
      cal_mode_r     <= 1'b0;
      cal_used_r     <= '0;
      north_offs_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SAMPLE_COUNT: sample_count_r <= pwdata[CNT_W-1:0];
        REG_CAL_MODE:     cal_mode_r     <= pwdata[0];
        REG_CAL_USED:     cal_used_r     <= pwdata[4:0];
        REG_NORTH_OFFS:   north_offs_r   <= $signed(pwdata[OFFS_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SAMPLE_COUNT: prdata = PDATA_W'(sample_count_r);
      REG_CAL_MODE:     prdata = PDATA_W'(cal_mode_r);
      REG_CAL_USED:     prdata = PDATA_W'(cal_used_r);
      REG_NORTH_OFFS:   prdata = PDATA_W'(north_offs_r);
      default:          prdata = '0;
    endcase
  end

  // Input transfer and burst accounting
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_sample = (in_data.command == CMD_SAMPLE);

  always_comb begin
    if (sample_count_r == '0) begin
      limit_c = CNT_W'(1);
    end else if (sample_count_r > CNT_W'(MAX_SAMPLES)) begin
      limit_c = CNT_W'(MAX_SAMPLES);
    end else begin
      limit_c = sample_count_r;
    end
  end

  assign taken_inc  = taken_r + 1'b1;
  assign sum_inc    = sum_r + SUM_W'(in_data.adc_sample);
  assign burst_done = in_acc && is_sample && (taken_inc >= limit_c);

  // Entries in use, clamped to the table depth
  assign used_c = (int'(cal_used_r) > CAL_ENTRIES) ? UW'(CAL_ENTRIES) : UW'(cal_used_r);

  // Calibration table memory: one write port, one registered read port
  assign wr_en   = in_acc && (in_data.command == CMD_CAL_WRITE) &&
                   (int'(in_data.entry_index) < CAL_ENTRIES);
  assign wr_addr = IDX_W'(in_data.entry_index);
  assign rd_en   = (state_r == S_WALK) && (issue_cnt_r < used_c);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cal_mem[wr_addr] <= {in_data.entry_adc, in_data.entry_heading};
    end
    if (rd_en) begin
      rd_q_r <= cal_mem[issue_cnt_r[IDX_W-1:0]];
    end
  end

  // Averaging divider
  wvd_div #(
    .N_W(SUM_W),
    .D_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (burst_done),
    .dividend (sum_inc),
    .divisor  (taken_inc),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Nearest-entry compare on the registered read data
  assign rd_adc  = rd_q_r[ENT_W-1:HEAD_W];
  assign rd_head = rd_q_r[HEAD_W-1:0];
  assign diff    = (avg_r >= rd_adc) ? (avg_r - rd_adc) : (rd_adc - avg_r);
  assign take    = rd_vld_r && ((rd_idx_r == '0) || (diff < best_r));

  // Linear map: divide by 4095 via x/4096 correction (quotient < 4096)
  assign lin_sum = (PROD_W+1)'(prod_r) + (PROD_W+1)'(prod_r >> LIN_SHIFT) + 1'b1;

  // Final reduction into 0..359; tot_r already carries a +720 bias
  always_comb begin
    if (tot_r >= TOT_W'(4 * DEG_FULL)) begin
      wrapped = tot_r - TOT_W'(4 * DEG_FULL);
    end else if (tot_r >= TOT_W'(3 * DEG_FULL)) begin
      wrapped = tot_r - TOT_W'(3 * DEG_FULL);
    end else if (tot_r >= TOT_W'(2 * DEG_FULL)) begin
      wrapped = tot_r - TOT_W'(2 * DEG_FULL);
    end else if (tot_r >= TOT_W'(DEG_FULL)) begin
      wrapped = tot_r - TOT_W'(DEG_FULL);
    end else begin
      wrapped = tot_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    taken_nxt     = taken_r;
    avg_nxt       = avg_r;
    issue_cnt_nxt = issue_cnt_r;
    best_nxt      = best_r;
    match_nxt     = match_r;
    raw_nxt       = raw_r;
    prod_nxt      = prod_r;
    tot_nxt       = tot_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_acc && is_sample) begin
          if (burst_done) begin
            sum_nxt   = '0;
            taken_nxt = '0;
            state_nxt = S_DIV;
          end else begin
            sum_nxt   = sum_inc;
            taken_nxt = taken_inc;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_nxt       = div_quo[SMP_W-1:0];
          match_nxt     = '0;
          issue_cnt_nxt = '0;
          state_nxt     = (cal_mode_r && (used_c != '0)) ? S_WALK : S_MUL;
        end
      end
      S_WALK: begin
        if (rd_en) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
        if (take) begin
          best_nxt  = diff;
          match_nxt = rd_idx_r;
          raw_nxt   = rd_head;
        end
        if (!rd_vld_r && (issue_cnt_r == used_c)) begin
          state_nxt = S_SUM;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(avg_r) * PROD_W'(DEG_MAX);
        state_nxt = S_LIN;
      end
      S_LIN: begin
        raw_nxt   = HEAD_W'(lin_sum >> LIN_SHIFT);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        tot_nxt   = TOT_W'(raw_r) + TOT_W'(north_offs_r) + TOT_W'(WRAP_BIAS);
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.heading_deg   = wrapped[HEAD_W-1:0];
          out_data_nxt.averaged_adc  = avg_r;
          out_data_nxt.matched_entry = IDX_FLD_W'(match_r);
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      taken_r     <= '0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      taken_r     <= taken_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    avg_r      <= avg_nxt;
    rd_idx_r   <= issue_cnt_r[IDX_W-1:0];
    best_r     <= best_nxt;
    match_r    <= match_nxt;
    raw_r      <= raw_nxt;
    prod_r     <= prod_nxt;
    tot_r      <= tot_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `WVD_ASSERT_IMPLY(a_taken_below_max, clk, rst_n, 1'b1, taken_r < CNT_W'(MAX_SAMPLES))
  `WVD_ASSERT_IMPLY(a_div_done_in_div, clk, rst_n, div_done, state_r == S_DIV)
  `WVD_ASSERT_IMPLY(a_walk_read_in_range, clk, rst_n, rd_vld_r,
                    (state_r == S_WALK) && (UW'(rd_idx_r) < used_c))
  `WVD_ASSERT_NEXT(a_wrap_loads_result, clk, rst_n, (state_r == S_WRAP) && out_free,
                   out_valid && (state_r == S_IDLE))

endmodule

`default_nettype wire
